### hdl/ghu_pkg.sv
// ----------------------------------------------------------------------------
// ghu_pkg: shared types and constants for the heading unwrap unit
// Fixed-point constants, CORDIC angle table and channel payload types.
// ----------------------------------------------------------------------------
package ghu_pkg;

  localparam int CordicStages = 16;
  localparam int LapLimit     = 4095;
  localparam int StepW        = 5;

  localparam logic signed [31:0] PiQ16     = 32'sd205887;
  localparam logic signed [31:0] HalfPiQ16 = 32'sd102944;
  localparam logic signed [31:0] TwoPiQ16  = 32'sd411775;
  localparam logic signed [47:0] GainQ30   = 48'sd652032875;
  localparam logic signed [63:0] OutMax    = 64'sd2147483647;

  localparam logic [0:0] CfgOffX = 1'b0;
  localparam logic [0:0] CfgOffY = 1'b1;

  typedef struct packed {
    logic               armed;
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_east;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] hull_x;
    logic signed [31:0] hull_y;
    logic signed [31:0] heading;
  } out_word_t;

  function automatic logic signed [31:0] atan_tab(input logic [StepW-1:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        5'd0: r = 32'sd51472;
        5'd1: r = 32'sd30385;
        5'd2: r = 32'sd16055;
        5'd3: r = 32'sd8150;
        5'd4: r = 32'sd4091;
        5'd5: r = 32'sd2047;
        5'd6: r = 32'sd1024;
        5'd7: r = 32'sd512;
        5'd8: r = 32'sd256;
        5'd9: r = 32'sd128;
        5'd10: r = 32'sd64;
        5'd11: r = 32'sd32;
        5'd12: r = 32'sd16;
        5'd13: r = 32'sd8;
        5'd14: r = 32'sd4;
        5'd15: r = 32'sd2;
        5'd16: r = 32'sd1;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

### hdl/ghu_stream_if.sv
// ----------------------------------------------------------------------------
// ghu_stream_if: valid/ready channel
// Carries one word per handshake; payload type is set per instance.
// ----------------------------------------------------------------------------
interface ghu_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/gps_heading_unwrap_antenna_offset_unit.sv
// ----------------------------------------------------------------------------
// gps_heading_unwrap_antenna_offset_unit: hull heading and position
// Quaternion yaw to compass heading, antenna offset removal, lap unwrap.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)  : one pose word per handshake (armed, north, east, quat).
//   out_if (source): one result word (hull_x, hull_y, heading) per armed word.
//   cfg_we_i/cfg_idx_i/cfg_data_i: antenna offset x (0) and y (1), Q.16.
// Sequence: the shared multiplier and the shared shift-add unit work in turn:
//   quaternion terms (6 multiply steps), 16 vectoring steps, wrap,
//   16 rotation steps, 4 offset multiply steps, sum/unwrap, then DONE.
//   A zero quaternion vector skips the vectoring steps.
//   A disarmed word gives no result; it clears the unwrap state.
// in ready is high only in IDLE. A finished result sits in the output
//   register; if the receiver stalls, the unit holds in DONE until taken.
// Reset clears the unwrap state (previous heading, laps, armed flag) and
//   loads the default offsets.
// ----------------------------------------------------------------------------
module gps_heading_unwrap_antenna_offset_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  ghu_stream_if.sink         in_if,
  ghu_stream_if.source       out_if,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i
);
  import ghu_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_QUAT = 8'b00000010,
    S_VEC  = 8'b00000100,
    S_WRAP = 8'b00001000,
    S_ROT  = 8'b00010000,
    S_OFFS = 8'b00100000,
    S_SUM  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  logic signed [19:0] offx_q, offy_q;
  // wrapped heading in [0, 2pi), kept unsigned
  logic        [18:0] prev_q, prev_d;
  logic signed [12:0] lap_q, lap_d;
  logic               armed_q, armed_d;

  // item payload
  logic signed [31:0] north_q, east_q;
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  // CORDIC working registers (x, y wide enough for Q.30 and quat sums)
  logic signed [47:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [31:0] cz_q, cz_d;
  logic               neg_q, neg_d;
  logic signed [31:0] h_q, h_d;
  // product accumulators for hull_x / hull_y (Q.46)
  logic signed [63:0] ax_q, ax_d, ay_q, ay_d;
  out_word_t          res_q, res_d;

  // shared multiplier: one 32x20 product per cycle
  logic signed [31:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [51:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared shift-add unit
  logic signed [47:0] sh_x, sh_y;
  logic signed [31:0] at;
  assign sh_x = cx_q >>> step_q;
  assign sh_y = cy_q >>> step_q;
  assign at   = atan_tab(step_q);

  logic signed [31:0] hw, hd, diff;
  logic signed [63:0] sx, sy, hout;

  assign in_if.ready    = (state_q == S_IDLE);
  assign out_if.valid   = (state_q == S_DONE);
  assign out_if.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q  <= 20'sd17203;
      offy_q  <= -20'sd18022;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOffX: offx_q <= cfg_data_i;
        CfgOffY: offy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    prev_d  = prev_q;
    lap_d   = lap_q;
    armed_d = armed_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; neg_d = neg_q; h_d = h_q;
    ax_d = ax_q; ay_d = ay_q; res_d = res_q;
    mul_a = '0; mul_b = '0;
    hw = '0; hd = '0; diff = '0; sx = '0; sy = '0; hout = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          if (!in_if.payload.armed) begin
            prev_d = '0; lap_d = '0; armed_d = 1'b0;
          end else begin
            state_d = S_QUAT; step_d = '0;
            cx_d = '0; cy_d = '0;
          end
        end
      end
      S_QUAT: begin
        // m11 = ww+xx-yy-zz into cx, m12 = 2(xy+wz) into cy
        case (step_q[1:0])
          2'd0: begin mul_a = 32'(qw_q); mul_b = 20'(qw_q); end
          2'd1: begin mul_a = 32'(qx_q); mul_b = 20'(qx_q); end
          2'd2: begin mul_a = 32'(qy_q); mul_b = 20'(qy_q); end
          default: begin mul_a = 32'(qz_q); mul_b = 20'(qz_q); end
        endcase
        case (step_q[1:0])
          2'd0, 2'd1: cx_d = cx_q + 48'(mul_p);
          default:    cx_d = cx_q - 48'(mul_p);
        endcase
        // cross terms also go through the shared multiplier: done
        // as two extra steps below
        step_d = step_q + 1'b1;
        if (step_q == 5'd3) step_d = 5'd4;
        if (step_q >= 5'd4) begin
          cx_d = cx_q;
          if (step_q == 5'd4) begin mul_a = 32'(qx_q); mul_b = 20'(qy_q); end
          else begin mul_a = 32'(qw_q); mul_b = 20'(qz_q); end
          cy_d = cy_q + (48'(mul_p) <<< 1);
          if (step_q == 5'd5) begin
            state_d = S_VEC; step_d = '0;
          end
        end
        if (state_d == S_VEC) begin
          // prerotation into the right half plane
          cz_d = '0;
          if (cx_q < 0) begin
            if (cy_d >= 0) begin
              cx_d = cy_d; cy_d = -cx_q; cz_d = HalfPiQ16;
            end else begin
              cx_d = -cy_d; cy_d = cx_q; cz_d = -HalfPiQ16;
            end
          end
        end
      end
      S_VEC: begin
        if (cx_q == 0 && cy_q == 0 && step_q == '0) begin
          cz_d = '0; state_d = S_WRAP;
        end else begin
          if (cy_q > 0) begin
            cx_d = cx_q + sh_y; cy_d = cy_q - sh_x; cz_d = cz_q + at;
          end else begin
            cx_d = cx_q - sh_y; cy_d = cy_q + sh_x; cz_d = cz_q - at;
          end
          step_d = step_q + 1'b1;
          if (step_q == StepW'(CordicStages - 1)) state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        hw = HalfPiQ16 - cz_q;
        if (hw < 0) hw = hw + TwoPiQ16;
        if (hw >= TwoPiQ16) hw = hw - TwoPiQ16;
        h_d = hw;
        hd = hw;
        if (hd > PiQ16) hd = hd - TwoPiQ16;
        neg_d = 1'b0;
        if (hd > HalfPiQ16) begin hd = hd - PiQ16; neg_d = 1'b1; end
        else if (hd < -HalfPiQ16) begin hd = hd + PiQ16; neg_d = 1'b1; end
        cx_d = GainQ30; cy_d = '0; cz_d = hd;
        step_d = '0; state_d = S_ROT;
      end
      S_ROT: begin
        if (cz_q >= 0) begin
          cx_d = cx_q - sh_y; cy_d = cy_q + sh_x; cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + sh_y; cy_d = cy_q - sh_x; cz_d = cz_q + at;
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(CordicStages - 1)) begin
          if (neg_q) begin cx_d = -cx_d; cy_d = -cy_d; end
          state_d = S_OFFS; step_d = '0; ax_d = '0; ay_d = '0;
        end
      end
      S_OFFS: begin
        // c, s fit in 32 bits (|Q.30| <= ~1.0)
        case (step_q[1:0])
          2'd0: begin mul_a = cx_q[31:0]; mul_b = offx_q; ax_d = ax_q + 64'(mul_p); end
          2'd1: begin mul_a = cy_q[31:0]; mul_b = offy_q; ax_d = ax_q - 64'(mul_p); end
          2'd2: begin mul_a = cy_q[31:0]; mul_b = offx_q; ay_d = ay_q + 64'(mul_p); end
          default: begin mul_a = cx_q[31:0]; mul_b = offy_q; ay_d = ay_q + 64'(mul_p); end
        endcase
        step_d = step_q + 1'b1;
        if (step_q == 5'd3) state_d = S_SUM;
      end
      S_SUM: begin
        sx = 64'(east_q) + ((ax_q + (64'sd1 <<< 29)) >>> 30);
        sy = 64'(north_q) + ((ay_q + (64'sd1 <<< 29)) >>> 30);
        if (sx > OutMax) sx = OutMax; else if (sx < -OutMax) sx = -OutMax;
        if (sy > OutMax) sy = OutMax; else if (sy < -OutMax) sy = -OutMax;
        if (!armed_q) lap_d = '0;
        else begin
          diff = h_q - 32'(prev_q);
          if (diff > PiQ16) begin
            if (lap_q > -13'(LapLimit)) lap_d = lap_q - 1'b1;
          end else if (diff < -PiQ16) begin
            if (lap_q < 13'(LapLimit)) lap_d = lap_q + 1'b1;
          end
        end
        prev_d = h_q[18:0];
        armed_d = 1'b1;
        hout = 64'(h_q) + 64'(TwoPiQ16) * 64'(lap_d);
        res_d.hull_x = sx[31:0];
        res_d.hull_y = sy[31:0];
        res_d.heading = hout[31:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_if.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      prev_q  <= '0;
      lap_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      prev_q  <= prev_d;
      lap_q   <= lap_d;
      armed_q <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) begin
      north_q <= in_if.payload.pos_north;
      east_q  <= in_if.payload.pos_east;
      qw_q <= in_if.payload.quat_w;
      qx_q <= in_if.payload.quat_x;
      qy_q <= in_if.payload.quat_y;
      qz_q <= in_if.payload.quat_z;
    end
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; neg_q <= neg_d; h_q <= h_d;
    ax_q <= ax_d; ay_q <= ay_d; res_q <= res_d;
  end

endmodule

### hdl/ghu_checker.sv
// ----------------------------------------------------------------------------
// ghu_checker: port-level checks for the heading unwrap unit
// Watches the two channels and flags ordering slips.
// ----------------------------------------------------------------------------
module ghu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [95:0] out_payload_i
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while word pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("output word dropped");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i) else $error("result too early");
endmodule

bind gps_heading_unwrap_antenna_offset_unit ghu_checker u_ghu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_payload_i(out_if.payload)
);

### verif/gps_heading_unwrap_antenna_offset_unit_checker.sv
// ----------------------------------------------------------------------------
// gps_heading_unwrap_antenna_offset_unit_checker: result predictor and compare
// Watches both channels and the offset writes, predicts each result word from
// accepted armed pose words, and compares it field by field with the oldest one.
// ----------------------------------------------------------------------------
module gps_heading_unwrap_antenna_offset_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  ghu_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  ghu_pkg::out_word_t out_word_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import ghu_pkg::*;

  out_word_t       pose_q[$];
  logic [19:0]     off_x, off_y;
  longint          last_head, laps;
  bit              armed_seen;

  assign pending_o = pose_q.size();

  function automatic longint atan_step(int i);
    return (i < 24) ? longint'(atan_tab(i[StepW-1:0])) : 0;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HalfPiQ16;
      end else begin
        x = -y; y = t; z = -HalfPiQ16;
      end
    end
    for (int i = 0; i < CordicStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > OutMax) return OutMax;
    if (v < -OutMax) return -OutMax;
    return v;
  endfunction

  task automatic predict_pose(input in_word_t w);
    longint qw, qx, qy, qz, m11, m12, h, x, y, z, dx, dy, c, s, ox, oy;
    bit flip;
    out_word_t r;
    qw = w.quat_w; qx = w.quat_x; qy = w.quat_y; qz = w.quat_z;
    m11 = qw*qw + qx*qx - qy*qy - qz*qz;
    m12 = 2*(qx*qy + qw*qz);
    h = HalfPiQ16 - vec_angle(m12, m11);
    if (h < 0) h += TwoPiQ16;
    if (h >= TwoPiQ16) h -= TwoPiQ16;
    // rotation for sin/cos, folded into the right half plane
    x = GainQ30; y = 0; z = h; flip = 0;
    if (z > PiQ16) z -= TwoPiQ16;
    if (z > HalfPiQ16) begin
      z -= PiQ16; flip = 1;
    end else if (z < -HalfPiQ16) begin
      z += PiQ16; flip = 1;
    end
    for (int i = 0; i < CordicStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    ox = longint'($signed(off_x));
    oy = longint'($signed(off_y));
    r.hull_x = 32'(clamp_pos(longint'(w.pos_east) + ((c*ox - s*oy + (64'sd1 <<< 29)) >>> 30)));
    r.hull_y = 32'(clamp_pos(longint'(w.pos_north) + ((s*ox + c*oy + (64'sd1 <<< 29)) >>> 30)));
    if (!armed_seen) laps = 0;
    else if (h - last_head > PiQ16) begin
      if (laps > -LapLimit) laps--;
    end else if (h - last_head < -PiQ16) begin
      if (laps < LapLimit) laps++;
    end
    last_head = h;
    armed_seen = 1;
    r.heading = 32'(h + longint'(TwoPiQ16) * laps);
    pose_q.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      off_x <= 20'd17203;
      off_y <= 20'hFB99A;
      last_head = 0; laps = 0; armed_seen = 0;
      errors_o = 0;
      pose_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pose_q.size() == 0) report("unexpected word", 0, 0);
        else begin
          e = pose_q.pop_front();
          if (out_word_i.hull_x !== e.hull_x) report("hull_x", out_word_i.hull_x, e.hull_x);
          if (out_word_i.hull_y !== e.hull_y) report("hull_y", out_word_i.hull_y, e.hull_y);
          if (out_word_i.heading !== e.heading)
            report("heading", out_word_i.heading, e.heading);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_word_i.armed) predict_pose(in_word_i);
        else begin
          last_head = 0; laps = 0; armed_seen = 0;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgOffX) off_x <= cfg_data_i;
        else off_y <= cfg_data_i;
      end
    end
  end

endmodule

### verif/gps_heading_unwrap_antenna_offset_unit_tb.sv
// ----------------------------------------------------------------------------
// gps_heading_unwrap_antenna_offset_unit_tb: top of the heading unit bench
// Drives pose words and offset writes, with random gaps and receiver stalls;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module gps_heading_unwrap_antenna_offset_unit_tb;
  import ghu_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [0:0]  cfg_idx_i = CfgOffX;
  logic [19:0] cfg_data_i = '0;
  int          errors, pending;
  bit          calm;        // no idling in the closing stretch
  bit          stall_on = 1;

  ghu_stream_if #(.payload_t(in_word_t))  in_if ();
  ghu_stream_if #(.payload_t(out_word_t)) out_if ();

  gps_heading_unwrap_antenna_offset_unit i_dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  gps_heading_unwrap_antenna_offset_unit_checker i_chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_word_i(in_if.payload),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_word_i(out_if.payload),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 0;
    in_if.payload = '0;
  end

  // receiver: random stall bursts, none in the closing stretch
  initial begin
    out_if.ready = 0;
    forever begin
      @(negedge clk_i);
      if (!calm && stall_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      out_if.ready <= 1;
    end
  end

  initial begin
    #50_000_000;
    $display("gps_heading_unwrap_antenna_offset_unit_tb NOT OK");
    $finish;
  end

  // one word, held at the falling edge until taken at a rising edge;
  // valid is set with blocking writes so back to back words settle cleanly
  task automatic send_pose(input in_word_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_if.valid = 1;
    in_if.payload = w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_if.valid = 0;
  endtask

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 16'(-16384);
      1: return 16'd16384;
      2: return 16'($urandom);           // outside the nominal range too
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic in_word_t rand_pose(input bit arm);
    in_word_t w;
    w.armed = arm;
    w.pos_north = ($urandom_range(0, 5) == 0) ? (($urandom & 1) ? 32'h7FFFFFFF : 32'h80000001)
                                             : $urandom;
    w.pos_east  = ($urandom_range(0, 5) == 0) ? (($urandom & 1) ? 32'h7FFFFFFF : 32'h80000001)
                                             : $urandom;
    w.quat_w = rand_quat(); w.quat_x = rand_quat();
    w.quat_y = rand_quat(); w.quat_z = rand_quat();
    return w;
  endfunction

  function automatic in_word_t yaw_pose(input logic signed [15:0] w, input logic signed [15:0] z);
    in_word_t p;
    p = rand_pose(1);
    p.quat_w = w; p.quat_z = z; p.quat_x = 0; p.quat_y = 0;
    return p;
  endfunction

  // offsets are only written once every result is back and the unit is idle
  task automatic write_offsets(input logic [19:0] ox, input logic [19:0] oy);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= CfgOffX; cfg_data_i <= ox;
    @(negedge clk_i);
    cfg_idx_i <= CfgOffY; cfg_data_i <= oy;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    in_word_t w;
    int phase_len;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: extremes, zero quaternion, disarm, turning laps
    w = '0; w.armed = 1;
    send_pose(w);                              // zero quaternion vector
    w = rand_pose(1); w.pos_north = 32'h7FFFFFFF; w.pos_east = 32'h7FFFFFFF;
    w.quat_w = 16384; w.quat_x = 16384; w.quat_y = 16384; w.quat_z = 16384;
    send_pose(w);
    w.pos_north = 32'h80000001; w.pos_east = 32'h80000000;
    w.quat_w = -16384; w.quat_x = -16384; w.quat_y = -16384; w.quat_z = -16384;
    send_pose(w);
    w.quat_w = 16'h8000; w.quat_x = 16'h7FFF; send_pose(w);
    send_pose(rand_pose(0));                   // disarm clears unwrap
    send_pose(rand_pose(0));
    // yaw steps of about a quarter turn, wraps the heading both ways
    for (int k = 0; k < 8; k++) send_pose(yaw_pose(k[0] ? 11585 : (k[1] ? 0 : 16384),
                                                    k[0] ? 11585 : (k[1] ? 16384 : 0)));
    for (int k = 0; k < 6; k++) send_pose(yaw_pose(k[0] ? -11585 : 16384, k[0] ? 11585 : 0));

    write_offsets(20'h40000, 20'hC0000);       // large offsets of both signs
    for (int k = 0; k < 4; k++) send_pose(rand_pose(1));
    write_offsets(20'hFFFFF, 20'h7FFFF);       // outside range bit patterns

    // random phases: mostly armed yaw-only poses, some random poses and disarms
    for (int ph = 0; ph < 6; ph++) begin
      phase_len = 190;
      if (ph == 5) begin
        while (pending != 0) @(negedge clk_i); // sender holds until drained
        calm = 1;
      end
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 15) == 0) send_pose(rand_pose(0));
        else if ($urandom_range(0, 2) == 0) send_pose(rand_pose(1));
        else send_pose(yaw_pose(16'($urandom_range(0, 16384)),
                                16'($signed($urandom_range(0, 32768)) - 16384)));
      end
      if (ph < 4) write_offsets(20'($urandom), 20'($urandom));
      else if (ph == 4) write_offsets(20'd17203, 20'hFB99A);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("gps_heading_unwrap_antenna_offset_unit_tb OK");
    end else begin
      $display("gps_heading_unwrap_antenna_offset_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ghu_pkg.sv
hdl/ghu_stream_if.sv
hdl/gps_heading_unwrap_antenna_offset_unit.sv
hdl/ghu_checker.sv
verif/gps_heading_unwrap_antenna_offset_unit_checker.sv
verif/gps_heading_unwrap_antenna_offset_unit_tb.sv
